### hdl/mpt_pkg.sv
// Shared types, codes and reset values of the page table.
package mpt_pkg;

  localparam int CFG_LEVELS = 4;
  localparam int MAX_LEVELS = 4;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int LEVEL_BITS_MAX = 16;

  localparam logic VALID = 1'b1;

  // register indexes (byte address is four times the index)
  localparam logic [2:0] REG_LEVEL_COUNT  = 3'd0;
  localparam logic [2:0] REG_BITS_LEVEL_0 = 3'd1;
  localparam logic [2:0] REG_BITS_LEVEL_1 = 3'd2;
  localparam logic [2:0] REG_BITS_LEVEL_2 = 3'd3;
  localparam logic [2:0] REG_BITS_LEVEL_3 = 3'd4;

  localparam logic [2:0] LEVEL_COUNT_RESET = 3'd2;
  localparam logic [4:0] BITS_LEVEL_0_RESET = 5'd10;
  localparam logic [4:0] BITS_LEVEL_1_RESET = 5'd10;
  localparam logic [4:0] BITS_LEVEL_2_RESET = 5'd4;
  localparam logic [4:0] BITS_LEVEL_3_RESET = 5'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]                 level_count;
    logic [CFG_LEVELS-1:0][4:0] bits_level;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_ADDR,
    ST_CHECK,
    ST_NEED0,
    ST_NEED,
    ST_FIT,
    ST_CLRSET,
    ST_SWEEP,
    ST_LINK,
    ST_NEXT,
    ST_NF,
    ST_LEAF,
    ST_FINISH
  } walk_state_t;

endpackage

### hdl/multilevel_page_table.sv
// Top level of the radix page table: register bank, walk sequencer and entry store.
//
// Input channel (in_valid/in_ready) takes one beat of mode, virtual_address and
// frame_in; mode 0 looks the address up, mode 1 maps it to frame_in. Output
// channel (out_valid/out_ready) returns one beat of status and frame_out for
// every input beat, in order. Configuration goes through the APB port; write it
// only while no item is in flight.
// An item is split into level indices one level per cycle, then each level
// passes an add step (ST_ADDR) and a store read step (ST_CHECK) through the
// single read port; ST_FINISH then loads the output register that raises
// out_valid. An insert that allocates sizes the allocation in ST_NEED0, ST_NEED
// and ST_FIT, runs ST_CLRSET, ST_SWEEP, ST_LINK and ST_NEXT for each new node
// and commits it in ST_NF; ST_SWEEP clears the stale entries left when the
// configured widths have been changed after earlier inserts. One item is in
// work at a time; in_ready is high only while the sequencer is idle.
// After reset the store is cleared one entry a cycle, with in_ready low;
// configuration writes are taken during that pass.
// A result waits in the output register while out_ready is low; the next item
// may be accepted meanwhile and waits at its end until that beat is taken.
module multilevel_page_table #(
  parameter int STORE_DEPTH = 65536,
  parameter int FRAME_BITS  = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [mpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [mpt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [31:0]                  virtual_address,
  input  logic [FRAME_BITS-1:0]        frame_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [FRAME_BITS-1:0]        frame_out
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int VW = (FRAME_BITS > AW) ? FRAME_BITS : AW;
  localparam int DW = VW + 1;

  mpt_pkg::cfg_t cfg;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  mpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpt_walk #(
    .STORE_DEPTH (STORE_DEPTH),
    .FRAME_BITS  (FRAME_BITS)
  ) u_walk (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .virtual_address (virtual_address),
    .frame_in        (frame_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .frame_out       (frame_out),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  mpt_store #(
    .DEPTH (STORE_DEPTH),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // the clearing pass keeps both channels quiet straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("channel active straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while a walk is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == mpt_pkg::STATUS_OK || status == mpt_pkg::STATUS_MISS ||
                   status == mpt_pkg::STATUS_FULL))
    else $error("undefined status code");

  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mpt_pkg::STATUS_OK |-> frame_out == '0)
    else $error("frame returned with a miss or full status");

endmodule

### hdl/mpt_cfg.sv
// APB register bank holding the level count and the per-level index widths.
module mpt_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [mpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [mpt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output mpt_pkg::cfg_t                cfg
);

  logic [2:0] reg_idx;
  logic       wr;

  assign reg_idx = paddr[mpt_pkg::PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_count   <= mpt_pkg::LEVEL_COUNT_RESET;
      cfg.bits_level[0] <= mpt_pkg::BITS_LEVEL_0_RESET;
      cfg.bits_level[1] <= mpt_pkg::BITS_LEVEL_1_RESET;
      cfg.bits_level[2] <= mpt_pkg::BITS_LEVEL_2_RESET;
      cfg.bits_level[3] <= mpt_pkg::BITS_LEVEL_3_RESET;
    end else if (wr) begin
      if (reg_idx == mpt_pkg::REG_LEVEL_COUNT) begin
        cfg.level_count <= pwdata[2:0];
      end else if (reg_idx inside {[mpt_pkg::REG_BITS_LEVEL_0:mpt_pkg::REG_BITS_LEVEL_3]}) begin
        cfg.bits_level[2'(reg_idx - mpt_pkg::REG_BITS_LEVEL_0)] <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      mpt_pkg::REG_LEVEL_COUNT:  prdata = {29'd0, cfg.level_count};
      mpt_pkg::REG_BITS_LEVEL_0: prdata = {27'd0, cfg.bits_level[0]};
      mpt_pkg::REG_BITS_LEVEL_1: prdata = {27'd0, cfg.bits_level[1]};
      mpt_pkg::REG_BITS_LEVEL_2: prdata = {27'd0, cfg.bits_level[2]};
      mpt_pkg::REG_BITS_LEVEL_3: prdata = {27'd0, cfg.bits_level[3]};
      default:                   prdata = '0;
    endcase
  end

endmodule

### hdl/mpt_store.sv
// Entry store: one write port, one read port with registered read data.
module mpt_store #(
  parameter int DEPTH = 65536,
  parameter int DW    = 21
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/mpt_walk.sv
// Walk sequencer: splits the address, walks the levels, allocates and clears nodes.
module mpt_walk #(
  parameter int STORE_DEPTH = 65536,
  parameter int FRAME_BITS  = 20
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mpt_pkg::cfg_t                          cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   mode,
  input  logic [31:0]                            virtual_address,
  input  logic [FRAME_BITS-1:0]                  frame_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             status,
  output logic [FRAME_BITS-1:0]                  frame_out,
  output logic                                   mem_we,
  output logic [$clog2(STORE_DEPTH)-1:0]         mem_waddr,
  output logic [((FRAME_BITS > $clog2(STORE_DEPTH)) ? FRAME_BITS : $clog2(STORE_DEPTH)):0]
                                                 mem_wdata,
  output logic [$clog2(STORE_DEPTH)-1:0]         mem_raddr,
  input  logic [((FRAME_BITS > $clog2(STORE_DEPTH)) ? FRAME_BITS : $clog2(STORE_DEPTH)):0]
                                                 mem_rdata
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int VW = (FRAME_BITS > AW) ? FRAME_BITS : AW;
  localparam int SW = ((VW > 20) ? VW : 20) + 2;
  localparam logic [SW-1:0] DEPTH_W = SW'(STORE_DEPTH);

  function automatic logic [4:0] clamp_width(input logic [4:0] b);
    if (b == 5'd0) return 5'd1;
    if (b > 5'(mpt_pkg::LEVEL_BITS_MAX)) return 5'(mpt_pkg::LEVEL_BITS_MAX);
    return b;
  endfunction

  function automatic logic [2:0] levels_used(input logic [2:0] lc);
    logic [2:0] n;
    n = lc;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(mpt_pkg::CFG_LEVELS)) n = 3'(mpt_pkg::CFG_LEVELS);
    if (n > 3'(mpt_pkg::MAX_LEVELS)) n = 3'(mpt_pkg::MAX_LEVELS);
    return n;
  endfunction

  function automatic logic [SW-1:0] pow2(input logic [4:0] w);
    return SW'(1) << w;
  endfunction

  mpt_pkg::walk_state_t state, state_next;

  logic                  mode_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [63:0]           sh;
  logic [15:0]           idx [mpt_pkg::CFG_LEVELS];
  logic [1:0]            lvl;
  logic [2:0]            n_lv;
  logic [2:0]            jn;
  logic [SW-1:0]         base;
  logic [SW-1:0]         a;
  logic [SW-1:0]         alloc;
  logic [SW-1:0]         need;
  logic [SW-1:0]         end_addr;
  logic [SW-1:0]         sweep;
  logic [AW:0]           next_free;
  logic [AW:0]           hwm;
  logic [1:0]            res_status;
  logic [FRAME_BITS-1:0] res_frame;

  logic [4:0]    wid [mpt_pkg::CFG_LEVELS];
  logic [2:0]    n_use;
  logic [1:0]    lvl_up;
  logic          last;
  logic          last_up;
  logic [SW-1:0] add_a;
  logic [SW-1:0] add_b;
  logic [SW-1:0] sum;
  logic          sum_in;
  logic          sweep_go;
  logic          ent_valid;
  logic [VW-1:0] ent_val;
  logic          out_load;

  always_comb begin
    for (int i = 0; i < mpt_pkg::CFG_LEVELS; i++) begin
      wid[i] = clamp_width(cfg.bits_level[i]);
    end
  end

  assign n_use     = levels_used(cfg.level_count);
  assign lvl_up    = lvl + 2'd1;
  assign last      = ({1'b0, lvl} == (n_lv - 3'd1));
  assign last_up   = ({1'b0, lvl_up} == (n_lv - 3'd1));
  assign sum       = add_a + add_b;
  assign sum_in    = (sum < DEPTH_W);
  assign sweep_go  = (sweep < end_addr) && (sweep < SW'(hwm));
  // entries above the high-water mark have not been written since the clearing pass
  assign ent_valid = mem_rdata[VW] && (a < SW'(hwm));
  assign ent_val   = mem_rdata[VW-1:0];
  assign out_load  = (state == mpt_pkg::ST_FINISH) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mpt_pkg::ST_CLEAR:  if (sweep == DEPTH_W - SW'(1)) state_next = mpt_pkg::ST_IDLE;
      mpt_pkg::ST_IDLE:   if (in_valid) state_next = mpt_pkg::ST_SPLIT;
      mpt_pkg::ST_SPLIT:  if (last) state_next = mpt_pkg::ST_ADDR;
      mpt_pkg::ST_ADDR: begin
        if (!sum_in) state_next = mpt_pkg::ST_FINISH;
        else if (mode_q && last) state_next = mpt_pkg::ST_LEAF;
        else state_next = mpt_pkg::ST_CHECK;
      end
      mpt_pkg::ST_CHECK: begin
        if (mode_q) begin
          state_next = ent_valid ? mpt_pkg::ST_ADDR : mpt_pkg::ST_NEED0;
        end else if (!ent_valid || last) begin
          state_next = mpt_pkg::ST_FINISH;
        end else begin
          state_next = mpt_pkg::ST_ADDR;
        end
      end
      mpt_pkg::ST_NEED0:  state_next = mpt_pkg::ST_NEED;
      mpt_pkg::ST_NEED:   if (jn >= n_lv) state_next = mpt_pkg::ST_FIT;
      mpt_pkg::ST_FIT:    state_next = (sum > DEPTH_W) ? mpt_pkg::ST_FINISH : mpt_pkg::ST_CLRSET;
      mpt_pkg::ST_CLRSET: state_next = mpt_pkg::ST_SWEEP;
      mpt_pkg::ST_SWEEP:  if (!sweep_go) state_next = mpt_pkg::ST_LINK;
      mpt_pkg::ST_LINK:   state_next = mpt_pkg::ST_NEXT;
      mpt_pkg::ST_NEXT:   state_next = last_up ? mpt_pkg::ST_NF : mpt_pkg::ST_CLRSET;
      mpt_pkg::ST_NF:     state_next = mpt_pkg::ST_LEAF;
      mpt_pkg::ST_LEAF:   state_next = mpt_pkg::ST_FINISH;
      mpt_pkg::ST_FINISH: if (!out_valid || out_ready) state_next = mpt_pkg::ST_IDLE;
      default:            state_next = mpt_pkg::ST_CLEAR;
    endcase
  end

  // shared adder operands and store controls
  always_comb begin
    add_a     = '0;
    add_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = sweep[AW-1:0];
    mem_wdata = '0;
    in_ready  = (state == mpt_pkg::ST_IDLE);
    case (state)
      mpt_pkg::ST_CLEAR: begin
        add_a  = sweep;
        add_b  = SW'(1);
        mem_we = 1'b1;
      end
      mpt_pkg::ST_SWEEP: begin
        add_a  = sweep;
        add_b  = SW'(1);
        mem_we = sweep_go;
      end
      mpt_pkg::ST_ADDR: begin
        add_a = base;
        add_b = SW'(idx[lvl]);
      end
      mpt_pkg::ST_NEED0: begin
        add_a = pow2(wid[0]);
        add_b = SW'(next_free);
      end
      mpt_pkg::ST_NEED: begin
        add_a = need;
        add_b = pow2(wid[jn[1:0]]);
      end
      mpt_pkg::ST_FIT: begin
        add_a = alloc;
        add_b = need;
      end
      mpt_pkg::ST_CLRSET: begin
        add_a = alloc;
        add_b = pow2(wid[lvl_up]);
      end
      mpt_pkg::ST_NEXT: begin
        add_a = alloc;
        add_b = SW'(idx[lvl_up]);
      end
      mpt_pkg::ST_NF: begin
        add_a = SW'(next_free);
        add_b = need;
      end
      mpt_pkg::ST_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = a[AW-1:0];
        mem_wdata = {mpt_pkg::VALID, alloc[VW-1:0]};
      end
      mpt_pkg::ST_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = a[AW-1:0];
        mem_wdata = {mpt_pkg::VALID, VW'(frame_q)};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign mem_raddr = sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) state <= mpt_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // control and allocation state
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      next_free <= '0;
      hwm       <= '0;
    end else begin
      case (state)
        mpt_pkg::ST_CLEAR:  sweep <= sum;
        mpt_pkg::ST_CLRSET: sweep <= alloc;
        mpt_pkg::ST_SWEEP:  if (sweep_go) sweep <= sum;
        mpt_pkg::ST_NF:     next_free <= sum[AW:0];
        mpt_pkg::ST_LINK, mpt_pkg::ST_LEAF: begin
          if (a >= SW'(hwm)) hwm <= a[AW:0] + {{AW{1'b0}}, 1'b1};
        end
        default: ;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      mpt_pkg::ST_IDLE: begin
        mode_q  <= mode;
        frame_q <= frame_in;
        sh      <= {virtual_address, 32'd0};
        n_lv    <= n_use;
        lvl     <= 2'd0;
      end
      mpt_pkg::ST_SPLIT: begin
        idx[lvl] <= sh[63:48] >> (5'd16 - wid[lvl]);
        sh       <= sh << wid[lvl];
        lvl      <= last ? 2'd0 : lvl_up;
        base     <= '0;
      end
      mpt_pkg::ST_ADDR: begin
        a <= sum;
        if (!sum_in) begin
          res_status <= mode_q ? mpt_pkg::STATUS_FULL : mpt_pkg::STATUS_MISS;
          res_frame  <= '0;
        end
      end
      mpt_pkg::ST_CHECK: begin
        base <= SW'(ent_val);
        if (!mode_q && (!ent_valid || last)) begin
          res_status <= ent_valid ? mpt_pkg::STATUS_OK : mpt_pkg::STATUS_MISS;
          res_frame  <= ent_valid ? ent_val[FRAME_BITS-1:0] : '0;
        end
        if (ent_valid && !last) lvl <= lvl_up;
      end
      mpt_pkg::ST_NEED0: begin
        alloc <= sum;
        need  <= '0;
        jn    <= {1'b0, lvl_up};
      end
      mpt_pkg::ST_NEED: begin
        if (jn < n_lv) begin
          need <= sum;
          jn   <= jn + 3'd1;
        end
      end
      mpt_pkg::ST_FIT: begin
        res_status <= mpt_pkg::STATUS_FULL;
        res_frame  <= '0;
      end
      mpt_pkg::ST_CLRSET: end_addr <= sum;
      mpt_pkg::ST_NEXT: begin
        a     <= sum;
        alloc <= end_addr;
        lvl   <= lvl_up;
      end
      mpt_pkg::ST_LEAF: begin
        res_status <= mpt_pkg::STATUS_OK;
        res_frame  <= '0;
      end
      default: ;
    endcase
  end

  // output register: holds the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= res_status;
      frame_out <= res_frame;
    end
  end

endmodule

### bench/tb_multilevel_page_table.sv
// Self-checking bench for the radix page table: directed walks, then random phases.
module tb_multilevel_page_table;

  localparam int STORE_DEPTH   = 65536;
  localparam int FRAME_W       = 20;
  localparam int RUN_LIMIT     = 6_000_000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 70;
  localparam int POOL_SIZE     = 12;
  localparam int TAIL_CYCLES   = 60;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;
  localparam bit   TYPED       = 1'b1;
  localparam bit   PREDICTED   = 1'b0;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame;
  } walk_result_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [2:0]         reg_idx;
    logic [4:0]         reg_val;
    logic               op;
    logic [31:0]        va;
    logic [FRAME_W-1:0] frame;
    bit                 typed;
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_out;
  } script_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [mpt_pkg::PADDR_W-1:0] paddr = '0;
  logic [mpt_pkg::PDATA_W-1:0] pwdata = '0;
  logic [mpt_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        mode = 1'b0;
  logic [31:0]                 virtual_address = '0;
  logic [FRAME_W-1:0]          frame_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  status;
  logic [FRAME_W-1:0]          frame_out;

  multilevel_page_table dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .virtual_address(virtual_address), .frame_in(frame_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .frame_out(frame_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the table and its geometry
  bit          pt_valid [STORE_DEPTH];
  int unsigned pt_value [STORE_DEPTH];
  int unsigned pt_bump = 0;
  logic [2:0]  cfg_levels = mpt_pkg::LEVEL_COUNT_RESET;
  logic [4:0]  cfg_width [mpt_pkg::CFG_LEVELS];

  walk_result_t pending_results[$];
  script_row_t  script[$];
  walk_result_t head;
  int           fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           tx_idle_on = 1'b1;
  logic         rx_idle_on = 1'b1;
  int           rx_hold = 0;

  function automatic int unsigned level_width(int l);
    int unsigned w;
    w = 32'(cfg_width[l]);
    if (w < 1) w = 1;
    if (w > mpt_pkg::LEVEL_BITS_MAX) w = mpt_pkg::LEVEL_BITS_MAX;
    return w;
  endfunction

  function automatic void walk_table(input logic m, input logic [31:0] va,
                                     input logic [FRAME_W-1:0] fr, output walk_result_t res);
    int unsigned     idx [mpt_pkg::CFG_LEVELS];
    int unsigned     n, w, used, miss;
    longint unsigned base, a, alloc, need, sz;
    logic [63:0]     wide;
    bit              stop, full;
    n = 32'(cfg_levels);
    if (n < 1) n = 1;
    if (n > mpt_pkg::MAX_LEVELS) n = mpt_pkg::MAX_LEVELS;
    // cut fields from the top; bits below bit zero read as zero
    wide = {va, 32'h0};
    used = 0;
    for (int i = 0; i < n; i++) begin
      w = level_width(i);
      idx[i] = 32'((wide >> (64 - used - w)) & ((64'd1 << w) - 64'd1));
      used += w;
    end
    res.status = mpt_pkg::STATUS_MISS;
    res.frame  = '0;
    base = 0;
    a = 0;
    stop = 1'b0;
    full = 1'b0;
    if (m == MODE_LOOKUP) begin
      for (int i = 0; i < n && !stop; i++) begin
        a = base + idx[i];
        if (a >= STORE_DEPTH || !pt_valid[a]) begin
          stop = 1'b1;
        end else if (i == n - 1) begin
          res.status = mpt_pkg::STATUS_OK;
          res.frame  = pt_value[a][FRAME_W-1:0];
          stop = 1'b1;
        end else begin
          base = 64'(pt_value[a]);
        end
      end
    end else begin
      miss = n;
      for (int i = 0; i < n && !stop; i++) begin
        a = base + idx[i];
        if (a >= STORE_DEPTH) begin
          full = 1'b1;
          stop = 1'b1;
        end else if (i == n - 1) begin
          stop = 1'b1;
        end else if (!pt_valid[a]) begin
          miss = i;
          stop = 1'b1;
        end else begin
          base = 64'(pt_value[a]);
        end
      end
      if (!full && miss < n) begin
        alloc = (64'd1 << level_width(0)) + pt_bump;
        need = 0;
        for (int j = miss + 1; j < n; j++) need += 64'd1 << level_width(j);
        if (alloc + need > STORE_DEPTH) begin
          full = 1'b1;
        end else begin
          // take and clear each missing node, link it, descend
          for (int j = miss; j + 1 < n; j++) begin
            sz = 64'd1 << level_width(j + 1);
            for (longint unsigned k = 0; k < sz; k++) begin
              pt_valid[alloc + k] = 1'b0;
              pt_value[alloc + k] = 0;
            end
            pt_valid[a] = mpt_pkg::VALID;
            pt_value[a] = 32'(alloc);
            a = alloc + idx[j + 1];
            alloc += sz;
          end
          pt_bump = 32'(alloc - (64'd1 << level_width(0)));
        end
      end
      if (full) begin
        res.status = mpt_pkg::STATUS_FULL;
      end else begin
        pt_valid[a] = mpt_pkg::VALID;
        pt_value[a] = 32'(fr);
        res.status = mpt_pkg::STATUS_OK;
      end
    end
  endfunction

  function automatic logic [4:0] pick_width();
    int r;
    r = int'($urandom_range(0, 19));
    if (r < 14) return 5'($urandom_range(1, 4));
    if (r < 17) return 5'($urandom_range(5, 7));
    if (r == 17) return 5'd0;
    return 5'($urandom_range(16, 31));
  endfunction

  function automatic void cfg_row(logic [2:0] idx, logic [4:0] val);
    script_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    script.push_back(r);
  endfunction

  function automatic void item_row(logic m, logic [31:0] va, logic [FRAME_W-1:0] fr,
                                   bit typed, logic [1:0] st, logic [FRAME_W-1:0] fo);
    script_row_t r;
    r = '0;
    r.op        = m;
    r.va        = va;
    r.frame     = fr;
    r.typed     = typed;
    r.status    = st;
    r.frame_out = fo;
    script.push_back(r);
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [4:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(mpt_pkg::PDATA_W-5){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mpt_pkg::REG_LEVEL_COUNT:  cfg_levels   = val[2:0];
      mpt_pkg::REG_BITS_LEVEL_0: cfg_width[0] = val;
      mpt_pkg::REG_BITS_LEVEL_1: cfg_width[1] = val;
      mpt_pkg::REG_BITS_LEVEL_2: cfg_width[2] = val;
      mpt_pkg::REG_BITS_LEVEL_3: cfg_width[3] = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_item(input logic m, input logic [31:0] va, input logic [FRAME_W-1:0] fr,
                           input bit typed, input logic [1:0] st,
                           input logic [FRAME_W-1:0] fo);
    walk_result_t res;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    mode            <= m;
    virtual_address <= va;
    frame_in        <= fr;
    do @(posedge clk); while (!in_ready);
    walk_table(m, va, fr, res);
    if (typed) begin
      res.status = st;
      res.frame  = fo;
    end
    pending_results.push_back(res);
  endtask

  // receiver: while rx_idle_on is set, drops out_ready at random in bursts counted by rx_hold
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold   <= int'($urandom_range(0, 9));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: status %0d frame_out %0h", status, frame_out);
        fail_count++;
      end else begin
        head = pending_results.pop_front();
        if (status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, status);
          fail_count++;
        end
        if (frame_out !== head.frame) begin
          $error("frame_out: expected %0h, got %0h", head.frame, frame_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] addr_pool [POOL_SIZE];
    logic        m;
    logic [31:0] va;
    int          pick;
    cfg_width[0] = mpt_pkg::BITS_LEVEL_0_RESET;
    cfg_width[1] = mpt_pkg::BITS_LEVEL_1_RESET;
    cfg_width[2] = mpt_pkg::BITS_LEVEL_2_RESET;
    cfg_width[3] = mpt_pkg::BITS_LEVEL_3_RESET;

    // reset geometry: two levels of ten bits
    item_row(MODE_LOOKUP, 32'h0000_0000, 20'h00000, TYPED, mpt_pkg::STATUS_MISS, 20'h0);
    item_row(MODE_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF, TYPED, mpt_pkg::STATUS_MISS, 20'h0);
    item_row(MODE_INSERT, 32'h0000_0000, 20'hFFFFF, TYPED, mpt_pkg::STATUS_OK, 20'h0);
    item_row(MODE_LOOKUP, 32'h0000_0FFF, 20'h00000, TYPED, mpt_pkg::STATUS_OK, 20'hFFFFF);
    item_row(MODE_INSERT, 32'hFFFF_FFFF, 20'h00000, TYPED, mpt_pkg::STATUS_OK, 20'h0);
    item_row(MODE_LOOKUP, 32'hFFFF_FFFF, 20'h12345, TYPED, mpt_pkg::STATUS_OK, 20'h0);
    item_row(MODE_INSERT, 32'h0000_0ABC, 20'h5A5A5, TYPED, mpt_pkg::STATUS_OK, 20'h0);
    item_row(MODE_LOOKUP, 32'h0000_0000, 20'h00000, TYPED, mpt_pkg::STATUS_OK, 20'h5A5A5);
    item_row(MODE_LOOKUP, 32'h0000_1000, 20'h00000, TYPED, mpt_pkg::STATUS_MISS, 20'h0);
    item_row(MODE_LOOKUP, 32'h0040_0000, 20'h00000, TYPED, mpt_pkg::STATUS_MISS, 20'h0);
    // level count zero acts as one; a single root level spans the store
    cfg_row(mpt_pkg::REG_LEVEL_COUNT, 5'd0);
    cfg_row(mpt_pkg::REG_BITS_LEVEL_0, 5'd16);
    item_row(MODE_LOOKUP, 32'h0000_0000, 20'h00000, PREDICTED, mpt_pkg::STATUS_OK, 20'h0);
    item_row(MODE_INSERT, 32'hFFFF_0000, 20'h0F0F0, TYPED, mpt_pkg::STATUS_OK, 20'h0);
    item_row(MODE_LOOKUP, 32'hFFFF_ABCD, 20'h00000, TYPED, mpt_pkg::STATUS_OK, 20'h0F0F0);
    // count seven acts as four, widths clamp; fields run past bit zero
    cfg_row(mpt_pkg::REG_LEVEL_COUNT, 5'd7);
    cfg_row(mpt_pkg::REG_BITS_LEVEL_0, 5'd0);
    cfg_row(mpt_pkg::REG_BITS_LEVEL_1, 5'd31);
    cfg_row(mpt_pkg::REG_BITS_LEVEL_2, 5'd16);
    cfg_row(mpt_pkg::REG_BITS_LEVEL_3, 5'd16);
    item_row(MODE_INSERT, 32'h8000_0000, 20'h00001, TYPED, mpt_pkg::STATUS_FULL, 20'h0);
    item_row(MODE_LOOKUP, 32'h8000_0000, 20'h00000, TYPED, mpt_pkg::STATUS_MISS, 20'h0);
    item_row(MODE_LOOKUP, 32'h0000_0000, 20'h00000, PREDICTED, mpt_pkg::STATUS_OK, 20'h0);
    // two levels, one plus fourteen bits
    cfg_row(mpt_pkg::REG_LEVEL_COUNT, 5'd2);
    cfg_row(mpt_pkg::REG_BITS_LEVEL_1, 5'd14);
    item_row(MODE_INSERT, 32'h8000_0000, 20'h00077, TYPED, mpt_pkg::STATUS_OK, 20'h0);
    item_row(MODE_LOOKUP, 32'h8000_0000, 20'h00000, TYPED, mpt_pkg::STATUS_OK, 20'h00077);
    // widen level one beyond the node it points into
    cfg_row(mpt_pkg::REG_BITS_LEVEL_1, 5'd16);
    item_row(MODE_LOOKUP, 32'hFFFF_FFFF, 20'h00000, TYPED, mpt_pkg::STATUS_MISS, 20'h0);
    item_row(MODE_INSERT, 32'hFFFF_FFFF, 20'h00003, TYPED, mpt_pkg::STATUS_FULL, 20'h0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      if (script[r].is_cfg) begin
        wait_drained();
        apb_write(script[r].reg_idx, script[r].reg_val);
      end else begin
        send_item(script[r].op, script[r].va, script[r].frame,
                  script[r].typed, script[r].status, script[r].frame_out);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      tx_idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_on <= (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      apb_write(mpt_pkg::REG_LEVEL_COUNT, 5'($urandom_range(0, 7)));
      apb_write(mpt_pkg::REG_BITS_LEVEL_0, pick_width());
      apb_write(mpt_pkg::REG_BITS_LEVEL_1, pick_width());
      apb_write(mpt_pkg::REG_BITS_LEVEL_2, pick_width());
      apb_write(mpt_pkg::REG_BITS_LEVEL_3, pick_width());
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // halfway through the phase, hold off until the table is quiet
        if (k == PHASE_ITEMS / 2) wait_drained();
        m = (k < 8 || $urandom_range(0, 9) < 4) ? MODE_INSERT : MODE_LOOKUP;
        pick = int'($urandom_range(0, 9));
        if (pick < 5) va = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 7) va = addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                ^ (32'h1 << $urandom_range(0, 31));
        else va = $urandom;
        send_item(m, va, FRAME_W'($urandom), PREDICTED, mpt_pkg::STATUS_OK, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
